// File: src/gfl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Granular freeze looper package
// Shared widths, command codes and register indexes of the grain looper.
// ----------------------------------------------------------------------------
package gfl_pkg;

  localparam int DEF_BANK_LEN  = 8192;
  localparam int DEF_FADE_SPAN = 20;

  localparam int SAMPLE_W  = 16;
  localparam int OFFSET_W  = 13;
  localparam int LEN_W     = 14;
  localparam int RATE_W    = 24;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 2;
  localparam int ACTION_W  = 2;
  localparam int PHASE_W   = 32;
  localparam int FRAC_W    = 16;
  localparam int HI_W      = PHASE_W - FRAC_W;
  localparam int STEP_W    = HI_W + 2;
  localparam int POS_W     = LEN_W + 1;
  localparam int K_W       = POS_W + 1;

  localparam int OFFSET_MAX = (1 << OFFSET_W) - 1;
  localparam int LEN_MAX    = (1 << LEN_W) - 1;

  localparam int FADE_DIV = 32;
  localparam int FADE_SH  = $clog2(FADE_DIV);

  localparam logic [RATE_W-1:0] UNITY_RATE = RATE_W'(65536);

  typedef enum logic [ACTION_W-1:0] {
    ACT_SAMPLE = 2'd0,
    ACT_START  = 2'd1,
    ACT_STOP   = 2'd2
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OFFSET  = 2'd0,
    REG_LENGTH  = 2'd1,
    REG_RATE    = 2'd2,
    REG_REVERSE = 2'd3
  } reg_index_t;

endpackage
`default_nettype wire

// File: src/gfl_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gfl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: src/granular_freeze_looper_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Granular freeze looper
// Double-banked circular recorder with a looping, faded grain player.
//
//   Channel   Signals                               Direction
//   config    cfg_we, cfg_index, cfg_data           in, write only
//   input     in_valid, in_stall, action, sample_in in, valid/stall
//   output    out_valid, out_stall, sample_out      out, valid/stall
//
// One item is taken every cycle while in_stall is low; a sample item gives its
// result through the phase step, fade and address sum, bank reduction, memory
// read and output register. Commands give no result.
// Reset clears the control state; the two bank memories are not cleared.
// A held output stalls only the output register; the stages behind it keep
// filling, and in_stall rises once every stage holds an item.
// ----------------------------------------------------------------------------
module granular_freeze_looper_unit #(
  parameter int BANK_LEN  = gfl_pkg::DEF_BANK_LEN,
  parameter int FADE_SPAN = gfl_pkg::DEF_FADE_SPAN
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [gfl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [gfl_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [gfl_pkg::ACTION_W-1:0]        action,
  input  logic signed [gfl_pkg::SAMPLE_W-1:0] sample_in,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [gfl_pkg::SAMPLE_W-1:0] sample_out
);
  import gfl_pkg::*;

  localparam int AW     = $clog2(BANK_LEN);
  localparam int XW     = $clog2(OFFSET_MAX + LEN_MAX + 2 * BANK_LEN);
  localparam int QW     = XW - AW + 1;
  localparam int RS     = XW + AW;
  localparam int MW     = XW + 1;
  localparam int PROD_W = SAMPLE_W + K_W;

  localparam longint unsigned RECIP_L =
      ((64'd1 << RS) + 64'(BANK_LEN) - 64'd1) / 64'(BANK_LEN);
  localparam logic [MW-1:0] RECIP = MW'(RECIP_L);
  localparam logic [AW-1:0] WPOS_LAST = AW'(BANK_LEN - 1);
  localparam logic [XW:0] BANK_BIAS = (XW + 1)'(BANK_LEN);
  localparam logic signed [K_W-1:0] FADE_K = K_W'(FADE_SPAN);
  localparam logic signed [PROD_W-1:0] ROUND_ADJ = PROD_W'(FADE_DIV - 1);
  localparam logic signed [PROD_W-1:0] SAT_MAX = PROD_W'((1 << (SAMPLE_W - 1)) - 1);
  localparam logic signed [PROD_W-1:0] SAT_MIN = PROD_W'(-(1 << (SAMPLE_W - 1)));

  // Control state.
  logic [AW-1:0]       write_pos;
  logic                frozen_bank;
  logic                playing;
  logic [PHASE_W-1:0]  phase_acc;
  logic [AW-1:0]       anchor_pos;
  logic [OFFSET_W-1:0] grain_offset;
  logic [LEN_W-1:0]    grain_length;
  logic [RATE_W-1:0]   grain_rate;
  logic                grain_reverse;
  logic [OFFSET_W-1:0] pending_offset;
  logic [LEN_W-1:0]    pending_length;
  logic [RATE_W-1:0]   pending_rate;
  logic                pending_reverse;

  // Handshake.
  logic in_acc;
  logic out_ready;
  logic s1_ready, s2_ready, s3_ready, s4_ready;
  logic s1_v, s2_v, s3_v, s4_v;

  // Phase step.
  logic [PHASE_W-1:0]      phase_sum;
  logic [HI_W-1:0]         phase_hi;
  logic [STEP_W-1:0]       rev_pos;
  logic                    step_wrap;
  logic signed [POS_W-1:0] step_pos;

  // Stage 1: grain position captured.
  logic                    s1_play;
  logic [SAMPLE_W-1:0]     s1_raw;
  logic [AW-1:0]           s1_wpos;
  logic [1:0]              s1_wmask;
  logic                    s1_rbank;
  logic signed [POS_W-1:0] s1_pos;
  logic [LEN_W-1:0]        s1_len;
  logic [OFFSET_W-1:0]     s1_off;
  logic [AW-1:0]           s1_anchor;

  // Stage 2: fade factor and unreduced read address.
  logic signed [K_W-1:0] k_val;
  logic signed [K_W-1:0] pos_ext;
  logic                  fade_en;
  logic signed [K_W-1:0] fade_fac;
  logic [XW:0]           x_sum;
  logic                  s2_play;
  logic [SAMPLE_W-1:0]   s2_raw;
  logic [AW-1:0]         s2_wpos;
  logic [1:0]            s2_wmask;
  logic                  s2_rbank;
  logic [XW-1:0]         s2_x;
  logic                  s2_fade_en;
  logic signed [K_W-1:0] s2_fac;

  // Stage 3: quotient by the bank length.
  logic [RS+QW-1:0]      recip_prod;
  logic                  s3_play;
  logic [SAMPLE_W-1:0]   s3_raw;
  logic [AW-1:0]         s3_wpos;
  logic [1:0]            s3_wmask;
  logic                  s3_rbank;
  logic [XW-1:0]         s3_x;
  logic [QW-1:0]         s3_q;
  logic                  s3_fade_en;
  logic signed [K_W-1:0] s3_fac;

  // Stage 4: memory access.
  logic [XW-1:0]         q_times_len;
  logic [XW-1:0]         rem_full;
  logic [AW-1:0]         ram_raddr;
  logic                  ram_re;
  logic                  ram_we0, ram_we1;
  logic [SAMPLE_W-1:0]   rd0, rd1;
  logic                  s4_play;
  logic [SAMPLE_W-1:0]   s4_raw;
  logic                  s4_rbank;
  logic                  s4_fade_en;
  logic signed [K_W-1:0] s4_fac;

  // Output fade.
  logic signed [SAMPLE_W-1:0] rd_s;
  logic signed [PROD_W-1:0]   fade_prod;
  logic signed [PROD_W-1:0]   fade_adj;
  logic signed [PROD_W-1:0]   fade_q;
  logic signed [SAMPLE_W-1:0] fade_sat;
  logic signed [SAMPLE_W-1:0] play_val;

  assign out_ready = !out_valid || !out_stall;
  assign s4_ready  = !s4_v || out_ready;
  assign s3_ready  = !s3_v || s4_ready;
  assign s2_ready  = !s2_v || s3_ready;
  assign s1_ready  = !s1_v || s2_ready;
  assign in_stall  = !s1_ready;
  assign in_acc    = in_valid && s1_ready;

  always_comb begin
    phase_sum = phase_acc + PHASE_W'(grain_rate);
    phase_hi  = phase_sum[PHASE_W-1:FRAC_W];
    rev_pos   = STEP_W'(grain_length) - STEP_W'(phase_hi) - STEP_W'(1);
    if (grain_reverse) begin
      step_wrap = rev_pos[STEP_W-1];
      step_pos  = step_wrap ? POS_W'(grain_length) - POS_W'(1) : rev_pos[POS_W-1:0];
    end else begin
      step_wrap = phase_hi >= HI_W'(grain_length);
      step_pos  = step_wrap ? '0 : phase_hi[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pos       <= '0;
      frozen_bank     <= 1'b0;
      playing         <= 1'b0;
      phase_acc       <= '0;
      anchor_pos      <= '0;
      grain_offset    <= '0;
      grain_length    <= '0;
      grain_rate      <= UNITY_RATE;
      grain_reverse   <= 1'b0;
      pending_offset  <= '0;
      pending_length  <= '0;
      pending_rate    <= UNITY_RATE;
      pending_reverse <= 1'b0;
      s1_v            <= 1'b0;
      s2_v            <= 1'b0;
      s3_v            <= 1'b0;
      s4_v            <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (reg_index_t'(cfg_index))
          REG_OFFSET:  pending_offset  <= cfg_data[OFFSET_W-1:0];
          REG_LENGTH:  pending_length  <= cfg_data[LEN_W-1:0];
          REG_RATE:    pending_rate    <= cfg_data[RATE_W-1:0];
          REG_REVERSE: pending_reverse <= cfg_data[0];
          default: ;
        endcase
      end
      if (in_acc) begin
        case (action_t'(action))
          ACT_START: begin
            if (!playing) begin
              frozen_bank   <= !frozen_bank;
              anchor_pos    <= write_pos;
              playing       <= 1'b1;
              grain_offset  <= pending_offset;
              grain_length  <= pending_length;
              grain_rate    <= pending_rate;
              grain_reverse <= pending_reverse;
            end
          end
          ACT_STOP: begin
            playing <= 1'b0;
          end
          ACT_SAMPLE: begin
            write_pos <= (write_pos == WPOS_LAST) ? '0 : write_pos + AW'(1);
            if (playing) begin
              phase_acc <= step_wrap ? '0 : phase_sum;
              if (step_wrap) begin
                grain_offset  <= pending_offset;
                grain_length  <= pending_length;
                grain_rate    <= pending_rate;
                grain_reverse <= pending_reverse;
              end
            end
          end
          default: ;
        endcase
      end
      if (s1_ready) begin
        s1_v <= in_acc && (action_t'(action) == ACT_SAMPLE);
      end
      if (s2_ready) begin
        s2_v <= s1_v;
      end
      if (s3_ready) begin
        s3_v <= s2_v;
      end
      if (s4_ready) begin
        s4_v <= s3_v;
      end
      if (out_ready) begin
        out_valid <= s4_v;
      end
    end
  end

  always_comb begin
    pos_ext = {s1_pos[POS_W-1], s1_pos};
    k_val   = $signed(K_W'(s1_len)) - pos_ext;
    if (k_val < FADE_K) begin
      fade_en  = 1'b1;
      fade_fac = k_val;
    end else if (pos_ext < FADE_K) begin
      fade_en  = 1'b1;
      fade_fac = pos_ext;
    end else begin
      fade_en  = 1'b0;
      fade_fac = k_val;
    end
    x_sum = (XW + 1)'(s1_off) + (XW + 1)'(s1_anchor) + BANK_BIAS
          + {{(XW + 1 - POS_W){s1_pos[POS_W-1]}}, s1_pos};
  end

  assign recip_prod  = {{MW{1'b0}}, s2_x} * {{XW{1'b0}}, RECIP};
  assign q_times_len = XW'(s3_q) * XW'(BANK_LEN);
  assign rem_full    = s3_x - q_times_len;
  assign ram_raddr   = rem_full[AW-1:0];
  assign ram_re      = s4_ready && s3_v && s3_play;
  assign ram_we0     = s4_ready && s3_v && s3_wmask[0];
  assign ram_we1     = s4_ready && s3_v && s3_wmask[1];

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_play   <= playing;
      s1_raw    <= sample_in;
      s1_wpos   <= write_pos;
      s1_wmask  <= playing ? (frozen_bank ? 2'b01 : 2'b10) : 2'b11;
      s1_rbank  <= frozen_bank;
      s1_pos    <= step_pos;
      s1_len    <= step_wrap ? pending_length : grain_length;
      s1_off    <= step_wrap ? pending_offset : grain_offset;
      s1_anchor <= anchor_pos;
    end
    if (s2_ready) begin
      s2_play    <= s1_play;
      s2_raw     <= s1_raw;
      s2_wpos    <= s1_wpos;
      s2_wmask   <= s1_wmask;
      s2_rbank   <= s1_rbank;
      s2_x       <= x_sum[XW-1:0];
      s2_fade_en <= fade_en;
      s2_fac     <= fade_fac;
    end
    if (s3_ready) begin
      s3_play    <= s2_play;
      s3_raw     <= s2_raw;
      s3_wpos    <= s2_wpos;
      s3_wmask   <= s2_wmask;
      s3_rbank   <= s2_rbank;
      s3_x       <= s2_x;
      s3_q       <= recip_prod[RS +: QW];
      s3_fade_en <= s2_fade_en;
      s3_fac     <= s2_fac;
    end
    if (s4_ready) begin
      s4_play    <= s3_play;
      s4_raw     <= s3_raw;
      s4_rbank   <= s3_rbank;
      s4_fade_en <= s3_fade_en;
      s4_fac     <= s3_fac;
    end
    if (out_ready) begin
      sample_out <= s4_play ? play_val : s4_raw;
    end
  end

  gfl_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(BANK_LEN)
  ) u_bank0 (
    .clk  (clk),
    .we   (ram_we0),
    .waddr(s3_wpos),
    .wdata(s3_raw),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(rd0)
  );

  gfl_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(BANK_LEN)
  ) u_bank1 (
    .clk  (clk),
    .we   (ram_we1),
    .waddr(s3_wpos),
    .wdata(s3_raw),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(rd1)
  );

  always_comb begin
    rd_s      = s4_rbank ? rd1 : rd0;
    fade_prod = rd_s * s4_fac;
    fade_adj  = fade_prod + (fade_prod[PROD_W-1] ? ROUND_ADJ : '0);
    fade_q    = fade_adj >>> FADE_SH;
    if (fade_q > SAT_MAX) begin
      fade_sat = SAT_MAX[SAMPLE_W-1:0];
    end else if (fade_q < SAT_MIN) begin
      fade_sat = SAT_MIN[SAMPLE_W-1:0];
    end else begin
      fade_sat = fade_q[SAMPLE_W-1:0];
    end
    play_val = s4_fade_en ? fade_sat : rd_s;
  end

endmodule
`default_nettype wire

// File: tb/granular_freeze_looper_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Granular freeze looper testbench
// Primes both sample banks and then walks a short script of edge cases. A
// long random run of grain play follows. Every result is checked in order
// against a local model of the recorder and grain player, or a fixed value
// for scripted checks. The input idles and the output stalls at random.
// ----------------------------------------------------------------------------
module granular_freeze_looper_unit_tb;
  import gfl_pkg::*;

  localparam int BANK_LEN    = DEF_BANK_LEN;
  localparam int FADE_SPAN   = DEF_FADE_SPAN;
  localparam int PRIME_ITEMS = 256;
  localparam int RAND_ITEMS  = 620;
  localparam int SETTLE_CYC  = 10;
  localparam int HOLD_AT     = 100;
  localparam int HOLD_CYC    = 300;
  localparam int BURST_LO    = 400;
  localparam int BURST_HI    = 600;
  localparam logic [ACTION_W-1:0] ACT_UNKNOWN = 2'd3;

  typedef struct packed {
    logic        is_regs;
    logic [1:0]  act;
    logic [15:0] smp;
    logic        typed;
    logic [15:0] want;
    logic [12:0] off;
    logic [13:0] len;
    logic [23:0] rate;
    logic        rev;
  } script_row_t;

  logic                       clk;
  logic                       rst;
  logic                       cfg_we;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_W-1:0]           cfg_data;
  logic                       in_valid;
  logic                       in_stall;
  logic [ACTION_W-1:0]        action;
  logic signed [SAMPLE_W-1:0] sample_in;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [SAMPLE_W-1:0] sample_out;

  // Local copy of the looper state.
  logic signed [15:0] bank_mem [0:2*BANK_LEN-1];
  bit          bank_wr [0:2*BANK_LEN-1];
  logic [12:0] wr_pos;
  logic [12:0] anchor;
  logic        frozen;
  logic        playing;
  logic [31:0] phase;
  logic [12:0] g_off, p_off;
  logic [13:0] g_len, p_len;
  logic [23:0] g_rate, p_rate;
  logic        g_rev, p_rev;

  logic [15:0] sample_out_due [$];
  int errors;
  int tx_count;
  int rx_count;
  int n_starts;
  int n_wraps;

  granular_freeze_looper_unit dut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .action, .sample_in,
    .out_valid, .out_stall, .sample_out
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [15:0] fade_by(logic signed [15:0] s, int k);
    int q;
    q = (int'(s) * k) / FADE_DIV;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return 16'(q);
  endfunction

  // Tells whether the next sample item would read a written entry.
  function automatic bit read_written();
    logic [31:0] ph;
    int hi, len0, pos;
    logic [12:0] off;
    logic [12:0] idx;
    ph   = phase + {8'd0, g_rate};
    hi   = ph[31:16];
    len0 = g_len;
    off  = g_off;
    if (!g_rev) begin
      pos = hi;
      if (pos >= len0) begin
        pos = 0;
        off = p_off;
      end
    end else begin
      pos = len0 - hi - 1;
      if (pos < 0 || pos >= len0) begin
        pos = len0 - 1;
        off = p_off;
      end
    end
    idx = 13'(int'(off) + pos + int'(anchor));
    return bank_wr[{frozen, idx}];
  endfunction

  task automatic take_pending();
    g_off  = p_off;
    g_len  = p_len;
    g_rate = p_rate;
    g_rev  = p_rev;
  endtask

  task automatic looper_step(input logic [1:0] act, input logic signed [15:0] s,
                             output bit has_out, output logic [15:0] out_val,
                             output bit eff);
    int hi, len0, len, pos, k;
    logic [12:0] idx;
    logic signed [15:0] rd;
    has_out = 1'b0;
    out_val = '0;
    eff     = 1'b0;
    case (act)
      ACT_START: begin
        if (!playing) begin
          frozen  = ~frozen;
          anchor  = wr_pos;
          playing = 1'b1;
          take_pending();
          n_starts++;
          eff = 1'b1;
        end
      end
      ACT_STOP: begin
        eff     = playing;
        playing = 1'b0;
      end
      ACT_SAMPLE: begin
        eff     = 1'b1;
        has_out = 1'b1;
        if (!playing) begin
          bank_mem[{1'b0, wr_pos}] = s;
          bank_mem[{1'b1, wr_pos}] = s;
          bank_wr[{1'b0, wr_pos}]  = 1'b1;
          bank_wr[{1'b1, wr_pos}]  = 1'b1;
          wr_pos++;
          out_val = s;
        end else begin
          bank_mem[{~frozen, wr_pos}] = s;
          bank_wr[{~frozen, wr_pos}]  = 1'b1;
          wr_pos++;
          phase = phase + {8'd0, g_rate};
          hi    = phase[31:16];
          len0  = g_len;
          if (!g_rev) begin
            pos = hi;
            if (pos >= len0) begin
              phase = '0;
              pos   = 0;
              take_pending();
              n_wraps++;
            end
          end else begin
            pos = len0 - hi - 1;
            if (pos < 0 || pos >= len0) begin
              phase = '0;
              pos   = len0 - 1;
              take_pending();
              n_wraps++;
            end
          end
          len = g_len;
          idx = 13'(int'(g_off) + pos + int'(anchor));
          rd  = bank_mem[{frozen, idx}];
          k   = len - pos;
          if (k < FADE_SPAN) out_val = fade_by(rd, k);
          else if (pos < FADE_SPAN) out_val = fade_by(rd, pos);
          else out_val = rd;
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_item(input logic [1:0] act, input logic [15:0] smp,
                           input logic typed, input logic [15:0] want, output bit eff);
    bit has_out;
    logic [15:0] out_val;
    // A grain sample that would read an entry never written is sent as a stop.
    if (act == ACT_SAMPLE && playing && !read_written()) act = ACT_STOP;
    while (!(tx_count >= BURST_LO && tx_count < BURST_HI) && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    action    <= act;
    sample_in <= smp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    looper_step(act, smp, has_out, out_val, eff);
    if (has_out) sample_out_due.push_back(typed ? want : out_val);
    tx_count++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sample_out_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_regs(input logic [3:0] sel, input logic [12:0] off,
                            input logic [13:0] len, input logic [23:0] rate,
                            input logic rev);
    reg_index_t r;
    for (int i = 0; i < 4; i++) begin
      if (sel[i]) begin
        r = reg_index_t'(i);
        case (r)
          REG_OFFSET:  begin cfg_data <= CFG_W'(off);  p_off  = off;  end
          REG_LENGTH:  begin cfg_data <= CFG_W'(len);  p_len  = len;  end
          REG_RATE:    begin cfg_data <= CFG_W'(rate); p_rate = rate; end
          REG_REVERSE: begin cfg_data <= CFG_W'(rev);  p_rev  = rev;  end
          default: ;
        endcase
        cfg_index <= r;
        cfg_we    <= 1'b1;
        @(posedge clk);
      end
    end
    cfg_we <= 1'b0;
  endtask

  function automatic script_row_t mk_item(logic [1:0] act, logic [15:0] smp);
    script_row_t r;
    r     = '0;
    r.act = act;
    r.smp = smp;
    return r;
  endfunction

  function automatic script_row_t mk_check(logic [15:0] smp, logic [15:0] want);
    script_row_t r;
    r       = '0;
    r.act   = ACT_SAMPLE;
    r.smp   = smp;
    r.typed = 1'b1;
    r.want  = want;
    return r;
  endfunction

  function automatic script_row_t mk_regs(logic [12:0] off, logic [13:0] len,
                                         logic [23:0] rate, logic rev);
    script_row_t r;
    r         = '0;
    r.is_regs = 1'b1;
    r.off     = off;
    r.len     = len;
    r.rate    = rate;
    r.rev     = rev;
    return r;
  endfunction

  // Output side: checks results in order and stalls at random.
  initial begin
    int hold_left;
    bit held;
    logic [15:0] want;
    hold_left = 0;
    held      = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        if (sample_out_due.size() == 0) begin
          $error("sample_out: expected no item, got %0d", sample_out);
          errors++;
        end else begin
          want = sample_out_due.pop_front();
          if (sample_out !== want) begin
            $error("sample_out: expected %0d, got %0d", $signed(want), sample_out);
            errors++;
          end
        end
        rx_count++;
        if (rx_count == HOLD_AT && !held) begin
          hold_left = HOLD_CYC;
          held      = 1'b1;
        end
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (rx_count >= BURST_LO && rx_count < BURST_HI) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 28);
      end
    end
  end

  initial begin
    script_row_t script [$];
    bit eff;
    int n_rand;
    int pick;
    logic [1:0]  act;
    logic [15:0] smp;
    logic [12:0] nxt_off;
    logic [13:0] nxt_len;
    logic [23:0] nxt_rate;

    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_index <= REG_OFFSET;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    action    <= ACT_SAMPLE;
    sample_in <= '0;
    errors   = 0;
    tx_count = 0;
    rx_count = 0;
    n_starts = 0;
    n_wraps  = 0;
    n_rand   = 0;
    wr_pos   = '0;
    anchor   = '0;
    frozen   = 1'b0;
    playing  = 1'b0;
    phase    = '0;
    g_off    = '0;
    g_len    = '0;
    g_rate   = UNITY_RATE;
    g_rev    = 1'b0;
    p_off    = '0;
    p_len    = '0;
    p_rate   = UNITY_RATE;
    p_rev    = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Prime the start of both banks. Grain reads are kept on written entries.
    for (int i = 0; i < PRIME_ITEMS; i++) send_item(ACT_SAMPLE, 16'($urandom), 1'b0, '0, eff);

    script = '{
      mk_check(16'h7FFF, 16'h7FFF),
      mk_check(16'h8000, 16'h8000),
      mk_check(16'h0000, 16'h0000),
      mk_check(16'hFFFF, 16'hFFFF),
      mk_item(ACT_STOP, 16'h0000),
      mk_item(ACT_UNKNOWN, 16'h5A5A),
      mk_regs(13'h1FFF, 14'd0, UNITY_RATE, 1'b0),
      mk_item(ACT_START, 16'h0000),
      mk_check(16'h1234, 16'h0000),
      mk_item(ACT_START, 16'hA5A5),
      mk_item(ACT_STOP, 16'h0000),
      mk_regs(13'h1E00, 14'd8192, 24'hFFFFFF, 1'b0),
      mk_item(ACT_START, 16'h0000),
      mk_item(ACT_SAMPLE, 16'h7FFF),
      mk_item(ACT_SAMPLE, 16'h8000),
      mk_item(ACT_STOP, 16'h0000),
      mk_regs(13'd0, 14'd0, UNITY_RATE, 1'b1),
      mk_item(ACT_START, 16'h0000),
      mk_item(ACT_SAMPLE, 16'h0001),
      mk_item(ACT_STOP, 16'h0000),
      mk_regs(13'd8182, 14'd3, UNITY_RATE, 1'b1),
      mk_item(ACT_START, 16'h0000),
      mk_item(ACT_SAMPLE, 16'h7FFF),
      mk_regs(13'd8182, 14'd1, UNITY_RATE, 1'b1),
      mk_item(ACT_SAMPLE, 16'h8000),
      mk_item(ACT_SAMPLE, 16'h8000),
      mk_item(ACT_STOP, 16'h0000),
      mk_regs(13'd8132, 14'd40, 24'hFFFFFF, 1'b1),
      mk_item(ACT_START, 16'h0000),
      mk_regs(13'd8132, 14'd0, 24'hFFFFFF, 1'b1),
      mk_item(ACT_SAMPLE, 16'h8000),
      mk_item(ACT_STOP, 16'h0000)
    };
    foreach (script[i]) begin
      if (script[i].is_regs) begin
        settle();
        write_regs(4'hF, script[i].off, script[i].len, script[i].rate, script[i].rev);
      end else begin
        send_item(script[i].act, script[i].smp, script[i].typed, script[i].want, eff);
      end
    end

    while (n_rand < RAND_ITEMS) begin
      settle();
      case ($urandom_range(5))
        0:       nxt_off = '0;
        1:       nxt_off = 13'h1FFF;
        2:       nxt_off = 13'($urandom);
        default: nxt_off = 13'(BANK_LEN - $urandom_range(80, 250));
      endcase
      case ($urandom_range(9))
        0:       nxt_len = '0;
        1:       nxt_len = 14'd1;
        2:       nxt_len = 14'd8192;
        3:       nxt_len = 14'h3FFF;
        4:       nxt_len = 14'($urandom);
        default: nxt_len = 14'($urandom_range(2, 80));
      endcase
      case ($urandom_range(7))
        0:       nxt_rate = '0;
        1:       nxt_rate = UNITY_RATE;
        2:       nxt_rate = 24'hFFFFFF;
        3:       nxt_rate = 24'($urandom);
        default: nxt_rate = 24'($urandom_range(1, 4 * 65536));
      endcase
      write_regs(4'($urandom_range(1, 15)), nxt_off, nxt_len, nxt_rate, 1'($urandom));
      if ($urandom_range(9) < 7) begin
        send_item(ACT_START, 16'($urandom), 1'b0, '0, eff);
        n_rand += eff;
      end
      repeat ($urandom_range(8, 50)) begin
        pick = $urandom_range(99);
        if (pick < 86) act = ACT_SAMPLE;
        else if (pick < 92) act = ACT_START;
        else if (pick < 97) act = ACT_STOP;
        else act = ACT_UNKNOWN;
        if ($urandom_range(15) == 0) smp = $urandom_range(1) ? 16'h7FFF : 16'h8000;
        else smp = 16'($urandom);
        send_item(act, smp, 1'b0, '0, eff);
        n_rand += eff;
      end
    end
    settle();

    $display("Sent %0d items and checked %0d samples across %0d grain starts",
             tx_count, rx_count, n_starts);
    $display("and %0d grain wraps, with forward, reversed and zero-length grains.", n_wraps);
    if (errors == 0 && sample_out_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
